FILE: rtl/core/cfuv_pkg.sv
// cfuv_pkg: shared types and constants of the cube face uv select core
// beat structs for both channels, face codes and the divider chain beat
// no dependencies
package cfuv_pkg;

  localparam int COMP_W  = 16;
  localparam int COORD_W = 16;

  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  localparam logic [COORD_W-1:0] COORD_HALF = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic [COORD_W-1:0] COORD_MAX  = {COORD_W{1'b1}};

  typedef struct packed {
    logic signed [COMP_W-1:0] dir_x;
    logic signed [COMP_W-1:0] dir_y;
    logic signed [COMP_W-1:0] dir_z;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         face;
    logic [COORD_W-1:0] coord_u;
    logic [COORD_W-1:0] coord_v;
    logic               degenerate;
  } out_beat_t;

  // one coordinate on its way through the restoring divider
  typedef struct packed {
    logic [COMP_W-1:0]  rem;
    logic [COORD_W-1:0] quo;
    logic               sat_lo;
    logic               sat_hi;
  } div_lane_t;

  typedef struct packed {
    logic [2:0]      face;
    logic            degenerate;
    logic [COMP_W:0] den;
    div_lane_t       lane_u;
    div_lane_t       lane_v;
  } cell_beat_t;

endpackage

FILE: rtl/core/cfuv_select.sv
// cfuv_select: first stage, picks the major axis, face and numerators
// sets up both divider lanes and the saturation cases
// depends on cfuv_pkg
module cfuv_select (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  input  cfuv_pkg::in_beat_t   up_beat,
  input  logic                 advance,
  output logic                 dn_valid,
  output cfuv_pkg::cell_beat_t dn_beat
);

  logic                 valid_r;
  logic                 valid_nxt;
  cfuv_pkg::cell_beat_t beat_r;
  cfuv_pkg::cell_beat_t beat_nxt;

  logic [cfuv_pkg::COMP_W-1:0]   ax;
  logic [cfuv_pkg::COMP_W-1:0]   ay;
  logic [cfuv_pkg::COMP_W-1:0]   az;
  logic [cfuv_pkg::COMP_W-1:0]   mag;
  logic signed [cfuv_pkg::COMP_W:0] ext_x;
  logic signed [cfuv_pkg::COMP_W:0] ext_y;
  logic signed [cfuv_pkg::COMP_W:0] ext_z;
  logic signed [cfuv_pkg::COMP_W:0] num_u;
  logic signed [cfuv_pkg::COMP_W:0] num_v;
  logic [2:0]                       face;
  logic                             x_major;
  logic                             y_major;

  // sets up one lane: shifted numerator n + m against den = 2m
  function automatic cfuv_pkg::div_lane_t lane_init(
    input logic signed [cfuv_pkg::COMP_W:0] n,
    input logic [cfuv_pkg::COMP_W-1:0]      m
  );
    logic signed [cfuv_pkg::COMP_W+1:0] num;
    logic signed [cfuv_pkg::COMP_W+1:0] den;
    cfuv_pkg::div_lane_t                lane;
    num = {n[cfuv_pkg::COMP_W], n} + $signed({2'b00, m});
    den = $signed({1'b0, m, 1'b0});
    lane.quo    = '0;
    lane.sat_lo = (num <= 0);
    lane.sat_hi = (num > 0) && ((den == 0) || (num >= den));
    if (lane.sat_lo || lane.sat_hi) begin
      lane.rem = '0;
    end else begin
      lane.rem = num[cfuv_pkg::COMP_W-1:0];
    end
    return lane;
  endfunction

  always_comb begin
    ext_x = {up_beat.dir_x[cfuv_pkg::COMP_W-1], up_beat.dir_x};
    ext_y = {up_beat.dir_y[cfuv_pkg::COMP_W-1], up_beat.dir_y};
    ext_z = {up_beat.dir_z[cfuv_pkg::COMP_W-1], up_beat.dir_z};
    ax = ext_x[cfuv_pkg::COMP_W] ? cfuv_pkg::COMP_W'(-ext_x) : ext_x[cfuv_pkg::COMP_W-1:0];
    ay = ext_y[cfuv_pkg::COMP_W] ? cfuv_pkg::COMP_W'(-ext_y) : ext_y[cfuv_pkg::COMP_W-1:0];
    az = ext_z[cfuv_pkg::COMP_W] ? cfuv_pkg::COMP_W'(-ext_z) : ext_z[cfuv_pkg::COMP_W-1:0];
    x_major = (ax > ay) && (ax > az);
    y_major = (ay > ax) && (ay > az);

    // ties fall through to the z faces
    if (x_major) begin
      mag = ax;
      if (!ext_x[cfuv_pkg::COMP_W]) begin
        face = cfuv_pkg::FACE_POS_X; num_u = ext_y; num_v = -ext_z;
      end else begin
        face = cfuv_pkg::FACE_NEG_X; num_u = ext_y; num_v = ext_z;
      end
    end else if (y_major) begin
      mag = ay;
      if (!ext_y[cfuv_pkg::COMP_W]) begin
        face = cfuv_pkg::FACE_POS_Y; num_u = -ext_z; num_v = ext_x;
      end else begin
        face = cfuv_pkg::FACE_NEG_Y; num_u = ext_z; num_v = ext_x;
      end
    end else begin
      mag = az;
      if (!ext_z[cfuv_pkg::COMP_W]) begin
        face = cfuv_pkg::FACE_POS_Z; num_u = ext_y; num_v = ext_x;
      end else begin
        face = cfuv_pkg::FACE_NEG_Z; num_u = ext_y; num_v = -ext_x;
      end
    end

    beat_nxt.face       = face;
    beat_nxt.degenerate = (up_beat.dir_x == '0) && (up_beat.dir_y == '0) &&
                          (up_beat.dir_z == '0);
    beat_nxt.den        = {mag, 1'b0};
    beat_nxt.lane_u     = lane_init(num_u, mag);
    beat_nxt.lane_v     = lane_init(num_v, mag);
    valid_nxt           = advance ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      beat_r <= beat_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_beat  = beat_r;

endmodule

FILE: rtl/core/cfuv_div_cell.sv
// cfuv_div_cell: one restoring division step for both coordinates
// settles one quotient bit per lane and hands the beat to the next cell
// depends on cfuv_pkg
module cfuv_div_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 up_valid,
  input  cfuv_pkg::cell_beat_t up_beat,
  input  logic                 advance,
  output logic                 dn_valid,
  output cfuv_pkg::cell_beat_t dn_beat
);

  logic                 valid_r;
  logic                 valid_nxt;
  cfuv_pkg::cell_beat_t beat_r;
  cfuv_pkg::cell_beat_t beat_nxt;

  function automatic cfuv_pkg::div_lane_t lane_step(
    input cfuv_pkg::div_lane_t       lane,
    input logic [cfuv_pkg::COMP_W:0] den
  );
    logic [cfuv_pkg::COMP_W:0] two_r;
    logic [cfuv_pkg::COMP_W:0] diff;
    logic                      ge;
    cfuv_pkg::div_lane_t       res;
    two_r = {lane.rem, 1'b0};
    diff  = two_r - den;
    ge    = (two_r >= den);
    res   = lane;
    res.rem = ge ? diff[cfuv_pkg::COMP_W-1:0] : two_r[cfuv_pkg::COMP_W-1:0];
    res.quo = {lane.quo[cfuv_pkg::COORD_W-2:0], ge};
    return res;
  endfunction

  always_comb begin
    beat_nxt        = up_beat;
    beat_nxt.lane_u = lane_step(up_beat.lane_u, up_beat.den);
    beat_nxt.lane_v = lane_step(up_beat.lane_v, up_beat.den);
    valid_nxt       = advance ? up_valid : valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && up_valid) begin
      beat_r <= beat_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_beat  = beat_r;

endmodule

FILE: rtl/core/cube_face_uv_select_core.sv
// cube_face_uv_select_core: top level of the cube face uv select block
// a select stage followed by a chain of restoring divider cells
// depends on cfuv_pkg, cfuv_select and cfuv_div_cell

// takes one direction beat per clock and returns the cube face (0..5 for
// +x -x +y -y +z -z) and u, v in unsigned q0.16. the select stage picks
// the axis of strictly largest magnitude (ties go to z) and sets up the
// numerators; then sixteen divider cells each settle one quotient bit of
// u and v. a beat passes from the select stage through each cell in turn;
// a new beat may enter every cycle while in_stall is low. each stage holds
// its beat while the one after it is full and stalled, so bubbles are
// squeezed out; input is still taken while a result waits at the output
// if a stage is empty. a zero vector reports degenerate with u = v = 0.5.
module cube_face_uv_select_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cfuv_pkg::in_beat_t  in_beat,
  output logic                out_valid,
  input  logic                out_stall,
  output cfuv_pkg::out_beat_t out_beat
);

  localparam int NSTG = cfuv_pkg::COORD_W + 1;

  // stage 0 is the select stage, stages 1..COORD_W are divider cells
  logic                 stg_valid [NSTG];
  cfuv_pkg::cell_beat_t stg_beat  [NSTG];
  logic                 stg_ready [NSTG+1];

  // a stage may load when it is empty or its contents move on
  always_comb begin
    stg_ready[NSTG] = !out_stall;
    for (int k = NSTG - 1; k >= 0; k--) begin
      stg_ready[k] = !stg_valid[k] || stg_ready[k+1];
    end
  end

  assign in_stall = !stg_ready[0];

  cfuv_select u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_beat  (in_beat),
    .advance  (stg_ready[0]),
    .dn_valid (stg_valid[0]),
    .dn_beat  (stg_beat[0])
  );

  // one quotient bit per cell, msb first
  for (genvar g = 1; g < NSTG; g++) begin : g_cell
    cfuv_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (stg_valid[g-1]),
      .up_beat  (stg_beat[g-1]),
      .advance  (stg_ready[g]),
      .dn_valid (stg_valid[g]),
      .dn_beat  (stg_beat[g])
    );
  end

  // last cell doubles as the output register; only the saturation
  // and degenerate overrides sit after it
  function automatic logic [cfuv_pkg::COORD_W-1:0] coord_final(
    input cfuv_pkg::div_lane_t lane,
    input logic                degen
  );
    logic [cfuv_pkg::COORD_W-1:0] c;
    if (degen) begin
      c = cfuv_pkg::COORD_HALF;
    end else if (lane.sat_hi) begin
      c = cfuv_pkg::COORD_MAX;
    end else if (lane.sat_lo) begin
      c = '0;
    end else begin
      c = lane.quo;
    end
    return c;
  endfunction

  always_comb begin
    out_valid           = stg_valid[NSTG-1];
    out_beat.face       = stg_beat[NSTG-1].face;
    out_beat.degenerate = stg_beat[NSTG-1].degenerate;
    out_beat.coord_u    = coord_final(stg_beat[NSTG-1].lane_u,
                                      stg_beat[NSTG-1].degenerate);
    out_beat.coord_v    = coord_final(stg_beat[NSTG-1].lane_v,
                                      stg_beat[NSTG-1].degenerate);
  end

endmodule

FILE: verif/testbench.sv
// testbench for cube_face_uv_select_core: directed table then random direction beats
// expected face/u/v come from an in-file model of the face pick and coordinate divide
// depends on cfuv_pkg and the rtl of cube_face_uv_select_core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_PER_PHASE = 130;
  localparam int NUM_PHASES     = 5;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 40;
  localparam int CYCLE_LIMIT    = 200000;

  typedef struct {
    cfuv_pkg::in_beat_t  dir;
    bit                  known;
    cfuv_pkg::out_beat_t uv;
  } dir_row_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  cfuv_pkg::in_beat_t  in_beat;
  logic                out_valid;
  logic                out_stall;
  cfuv_pkg::out_beat_t out_beat;

  cfuv_pkg::out_beat_t uv_due_q [$];
  cfuv_pkg::out_beat_t uv_for_offer;
  int                  bad_beats;
  int                  cycle_cnt;
  int                  send_idle_pct;
  int                  stall_pct;
  bit                  hold_go;
  bit                  hold_done;
  int                  hold_left;
  dir_row_t            dir_rows [$];

  cube_face_uv_select_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_beat   (in_beat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // u or v: (n + m) / (2m) in unsigned q0.16, clamped at both ends
  function automatic logic [cfuv_pkg::COORD_W-1:0] coord_of(longint n, longint m);
    longint num;
    longint den;
    longint q;
    num = n + m;
    den = 2 * m;
    if (num <= 0) return '0;
    if (den <= 0 || num >= den) return cfuv_pkg::COORD_MAX;
    q = (num <<< cfuv_pkg::COORD_W) / den;
    if (q > longint'(cfuv_pkg::COORD_MAX)) return cfuv_pkg::COORD_MAX;
    return q[cfuv_pkg::COORD_W-1:0];
  endfunction

  // face pick: strictly largest magnitude wins, anything else falls to z
  function automatic cfuv_pkg::out_beat_t face_uv_of(cfuv_pkg::in_beat_t d);
    longint              x, y, z, ax, ay, az, m, nu, nv;
    cfuv_pkg::out_beat_t r;
    x  = longint'($signed(d.dir_x));
    y  = longint'($signed(d.dir_y));
    z  = longint'($signed(d.dir_z));
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    r.degenerate = 1'b0;
    if (x == 0 && y == 0 && z == 0) begin
      r.face       = cfuv_pkg::FACE_POS_Z;
      r.coord_u    = cfuv_pkg::COORD_HALF;
      r.coord_v    = cfuv_pkg::COORD_HALF;
      r.degenerate = 1'b1;
      return r;
    end
    if (ax > ay && ax > az) begin
      m = ax;
      if (x >= 0) begin
        r.face = cfuv_pkg::FACE_POS_X; nu = y; nv = -z;
      end else begin
        r.face = cfuv_pkg::FACE_NEG_X; nu = y; nv = z;
      end
    end else if (ay > ax && ay > az) begin
      m = ay;
      if (y >= 0) begin
        r.face = cfuv_pkg::FACE_POS_Y; nu = -z; nv = x;
      end else begin
        r.face = cfuv_pkg::FACE_NEG_Y; nu = z; nv = x;
      end
    end else begin
      m = az;
      if (z >= 0) begin
        r.face = cfuv_pkg::FACE_POS_Z; nu = y; nv = x;
      end else begin
        r.face = cfuv_pkg::FACE_NEG_Z; nu = y; nv = -x;
      end
    end
    r.coord_u = coord_of(nu, m);
    r.coord_v = coord_of(nv, m);
    return r;
  endfunction

  function automatic cfuv_pkg::in_beat_t mk_dir(int x, int y, int z);
    cfuv_pkg::in_beat_t d;
    d.dir_x = x[cfuv_pkg::COMP_W-1:0];
    d.dir_y = y[cfuv_pkg::COMP_W-1:0];
    d.dir_z = z[cfuv_pkg::COMP_W-1:0];
    return d;
  endfunction

  function automatic dir_row_t plain(int x, int y, int z);
    dir_row_t r;
    r.dir   = mk_dir(x, y, z);
    r.known = 1'b0;
    r.uv    = '0;
    return r;
  endfunction

  function automatic dir_row_t known(int x, int y, int z, logic [2:0] f,
                                     logic [cfuv_pkg::COORD_W-1:0] u,
                                     logic [cfuv_pkg::COORD_W-1:0] v,
                                     logic deg);
    dir_row_t r;
    r.dir   = mk_dir(x, y, z);
    r.known = 1'b1;
    r.uv    = '{face: f, coord_u: u, coord_v: v, degenerate: deg};
    return r;
  endfunction

  function automatic int full_comp();
    return int'($urandom_range(65535)) - 32768;
  endfunction

  function automatic int rim_comp();
    case ($urandom_range(5))
      0:       return -32768;
      1:       return -32767;
      2:       return -1;
      3:       return 0;
      4:       return 1;
      default: return 32767;
    endcase
  endfunction

  function automatic int signed_mag(int a);
    return $urandom_range(1) ? a : -a;
  endfunction

  // random direction: mostly full range, plus ties, extremes, small values
  function automatic cfuv_pkg::in_beat_t rand_dir();
    int c [3];
    int a;
    int k;
    int sel;
    sel = $urandom_range(9);
    case (sel)
      4: begin
        foreach (c[i]) c[i] = int'($urandom_range(8)) - 4;
      end
      5: begin
        foreach (c[i]) c[i] = rim_comp();
      end
      6: begin
        // two equal magnitudes, third at, below or above them
        a = $urandom_range(32768);
        k = $urandom_range(2);
        c[k]         = signed_mag(a);
        c[(k+1) % 3] = signed_mag(a);
        case ($urandom_range(3))
          0:       c[(k+2) % 3] = 0;
          1:       c[(k+2) % 3] = signed_mag(a);
          2:       c[(k+2) % 3] = signed_mag($urandom_range(a));
          default: c[(k+2) % 3] = full_comp();
        endcase
      end
      7: begin
        // one axis clearly dominant
        a = $urandom_range(32768, 1);
        k = $urandom_range(2);
        foreach (c[i]) c[i] = int'($urandom_range(2 * a - 2)) - (a - 1);
        c[k] = signed_mag(a);
      end
      8: begin
        foreach (c[i]) c[i] = $urandom_range(1) ? 0 : full_comp();
      end
      default: begin
        foreach (c[i]) c[i] = full_comp();
      end
    endcase
    return mk_dir(c[0], c[1], c[2]);
  endfunction

  // offer one beat from the falling edge until it is taken
  task automatic offer_dir(cfuv_pkg::in_beat_t d, cfuv_pkg::out_beat_t uv);
    in_valid     = 1'b1;
    in_beat      = d;
    uv_for_offer = uv;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
      @(negedge clk);
    end
  endtask

  // receiver: random stall, plus one long hold-off counted here
  initial begin
    out_stall = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (hold_go && !hold_done) begin
        out_stall = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1'b1;
      end else begin
        out_stall = ($urandom_range(99) < stall_pct);
      end
    end
  end

  // accepted input beats queue their expectation, output beats are checked
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) uv_due_q.push_back(uv_for_offer);
    if (rst_n && out_valid && !out_stall) begin
      if (uv_due_q.size() == 0) begin
        bad_beats++;
        $display("%0t: unexpected beat face=%0d u=%0d v=%0d deg=%0b", $time,
                 out_beat.face, out_beat.coord_u, out_beat.coord_v, out_beat.degenerate);
      end else begin
        if (out_beat !== uv_due_q[0]) begin
          bad_beats++;
          $display({"%0t: mismatch exp face=%0d u=%0d v=%0d deg=%0b",
                    " got face=%0d u=%0d v=%0d deg=%0b"},
                   $time, uv_due_q[0].face, uv_due_q[0].coord_u, uv_due_q[0].coord_v,
                   uv_due_q[0].degenerate, out_beat.face, out_beat.coord_u,
                   out_beat.coord_v, out_beat.degenerate);
        end
        void'(uv_due_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    cfuv_pkg::in_beat_t d;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_beat       = '0;
    uv_for_offer  = '0;
    bad_beats     = 0;
    cycle_cnt     = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_go       = 1'b0;

    dir_rows = '{
      // zero vector
      known(0, 0, 0, cfuv_pkg::FACE_POS_Z, cfuv_pkg::COORD_HALF, cfuv_pkg::COORD_HALF,
            1'b1),
      // single axis extremes land at the face center
      known(32767, 0, 0, cfuv_pkg::FACE_POS_X, cfuv_pkg::COORD_HALF,
            cfuv_pkg::COORD_HALF, 1'b0),
      known(-32768, 0, 0, cfuv_pkg::FACE_NEG_X, cfuv_pkg::COORD_HALF,
            cfuv_pkg::COORD_HALF, 1'b0),
      known(0, 32767, 0, cfuv_pkg::FACE_POS_Y, cfuv_pkg::COORD_HALF,
            cfuv_pkg::COORD_HALF, 1'b0),
      known(0, -32768, 0, cfuv_pkg::FACE_NEG_Y, cfuv_pkg::COORD_HALF,
            cfuv_pkg::COORD_HALF, 1'b0),
      known(0, 0, 32767, cfuv_pkg::FACE_POS_Z, cfuv_pkg::COORD_HALF,
            cfuv_pkg::COORD_HALF, 1'b0),
      known(0, 0, -32768, cfuv_pkg::FACE_NEG_Z, cfuv_pkg::COORD_HALF,
            cfuv_pkg::COORD_HALF, 1'b0),
      // x and y tie with z zero: divide by zero, saturate by numerator sign
      known(100, 100, 0, cfuv_pkg::FACE_POS_Z, cfuv_pkg::COORD_MAX,
            cfuv_pkg::COORD_MAX, 1'b0),
      known(-100, -100, 0, cfuv_pkg::FACE_POS_Z, '0, '0, 1'b0),
      known(100, -100, 0, cfuv_pkg::FACE_POS_Z, '0, cfuv_pkg::COORD_MAX, 1'b0),
      // exact plus and minus one on a z face
      known(0, 100, 100, cfuv_pkg::FACE_POS_Z, cfuv_pkg::COORD_MAX,
            cfuv_pkg::COORD_HALF, 1'b0),
      known(0, -100, -100, cfuv_pkg::FACE_NEG_Z, '0, cfuv_pkg::COORD_HALF, 1'b0),
      // x and y tie above z: quotient leaves the unit range
      known(200, -200, 50, cfuv_pkg::FACE_POS_Z, '0, cfuv_pkg::COORD_MAX, 1'b0),
      // all three equal at the extremes
      known(-32768, -32768, -32768, cfuv_pkg::FACE_NEG_Z, '0, cfuv_pkg::COORD_MAX,
            1'b0),
      known(32767, 32767, 32767, cfuv_pkg::FACE_POS_Z, cfuv_pkg::COORD_MAX,
            cfuv_pkg::COORD_MAX, 1'b0),
      plain(32767, 12345, -20000),
      plain(-32768, 32767, -32767),
      plain(-32768, -32767, 32767),
      plain(1, 0, 0),
      plain(-1, 0, 0),
      plain(0, 1, -1),
      plain(5, -7, 3),
      plain(-3, 9, 2),
      plain(1000, -30000, 29999),
      plain(3, 2, 1)
    };

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (dir_rows[i])
      offer_dir(dir_rows[i].dir,
                dir_rows[i].known ? dir_rows[i].uv : face_uv_of(dir_rows[i].dir));

    // phases: no idling, sender idle, receiver stall, both, long hold-off
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        1:       begin send_idle_pct = 55; stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  stall_pct = 55; end
        3:       begin send_idle_pct = 32; stall_pct = 32; end
        default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
      if (ph == NUM_PHASES - 1) hold_go = 1'b1;
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        idle_gap();
        d = rand_dir();
        offer_dir(d, face_uv_of(d));
      end
    end
    in_valid  = 1'b0;
    stall_pct = 0;

    while (uv_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_beats == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
